>>> sv/stt_pkg.sv
// package for the software timer table: constants, status codes, fsm states
package stt_pkg;
    localparam int TIMER_SLOTS_DEF = 16;
    localparam int CONSUMER_COUNT_DEF = 16;
    localparam int MAX_FIRES_DEF = 63;
    localparam logic [31:0] END_OF_DAY_MS = 32'(23 * 3600 * 1000 + 59 * 60 * 1000 + 59000);

    localparam logic [2:0] KIND_SET = 3'd0;
    localparam logic [2:0] KIND_CANCEL = 3'd1;
    localparam logic [2:0] KIND_ADVANCE = 3'd2;
    localparam logic [2:0] KIND_START = 3'd3;
    localparam logic [2:0] KIND_END = 3'd4;

    localparam logic [3:0] ST_FIRED = 4'd0;
    localparam logic [3:0] ST_SET_OK = 4'd1;
    localparam logic [3:0] ST_DUP = 4'd2;
    localparam logic [3:0] ST_FULL = 4'd3;
    localparam logic [3:0] ST_ZERO = 4'd4;
    localparam logic [3:0] ST_CANCEL_OK = 4'd5;
    localparam logic [3:0] ST_NOT_FOUND = 4'd6;
    localparam logic [3:0] ST_ADV_DONE = 4'd7;
    localparam logic [3:0] ST_INCOMPLETE = 4'd8;
    localparam logic [3:0] ST_DAY_START = 4'd9;
    localparam logic [3:0] ST_DAY_END = 4'd10;
    localparam logic [3:0] ST_END_IGN = 4'd11;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_UPDATE,
        S_OUT
    } t_state;

    // compare unit control
    typedef struct packed {
        logic start;
        logic key_mode;
    } t_scan_ctl;
endpackage

>>> sv/stt_scan.sv
// shared compare unit: walks the slots one a cycle, finds key match or earliest timer and first free slot
module stt_scan #(
    parameter int TIMER_SLOTS = stt_pkg::TIMER_SLOTS_DEF,
    localparam int IW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  stt_pkg::t_scan_ctl i_ctl,
    input  logic [3:0]        i_key_cons,
    input  logic [31:0]       i_key_ev,
    output logic [IW-1:0]     o_rd_idx,
    input  logic              i_rd_valid,
    input  logic [3:0]        i_rd_cons,
    input  logic [31:0]       i_rd_ev,
    input  logic [31:0]       i_rd_due,
    output logic              o_done,
    output logic              o_found,
    output logic [IW-1:0]     o_best,
    output logic [31:0]       o_best_due,
    output logic              o_free_found,
    output logic [IW-1:0]     o_free_idx
);
    logic [IW:0]   r_cnt;
    logic          r_busy;
    logic          r_key;
    logic          r_found;
    logic [IW-1:0] r_best;
    logic [31:0]   r_due;
    logic [3:0]    r_cons;
    logic [31:0]   r_ev;
    logic          r_free;
    logic [IW-1:0] r_fidx;
    logic          better;
    logic          hit;

    assign o_rd_idx = r_cnt[IW-1:0];
    assign hit = i_rd_valid && i_rd_cons == i_key_cons && i_rd_ev == i_key_ev;
    assign better = i_rd_valid && (!r_found || i_rd_due < r_due ||
        (i_rd_due == r_due && (i_rd_cons < r_cons ||
        (i_rd_cons == r_cons && i_rd_ev < r_ev))));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt <= '0;
            r_found <= 1'b0;
            r_free <= 1'b0;
            r_key <= 1'b0;
        end else if (i_ctl.start) begin
            r_busy <= 1'b1;
            r_cnt <= '0;
            r_found <= 1'b0;
            r_free <= 1'b0;
            r_key <= i_ctl.key_mode;
        end else if (r_busy) begin
            if (!i_rd_valid && !r_free) begin
                r_free <= 1'b1;
                r_fidx <= r_cnt[IW-1:0];
            end
            if (r_key ? (hit && !r_found) : better) begin
                r_found <= 1'b1;
                r_best <= r_cnt[IW-1:0];
                r_due <= i_rd_due;
                r_cons <= i_rd_cons;
                r_ev <= i_rd_ev;
            end
            if (r_cnt == (IW+1)'(TIMER_SLOTS - 1)) r_busy <= 1'b0;
            r_cnt <= r_cnt + 1'b1;
        end
    end

    assign o_done = !r_busy && !i_ctl.start;
    assign o_found = r_found;
    assign o_best = r_best;
    assign o_best_due = r_due;
    assign o_free_found = r_free;
    assign o_free_idx = r_fidx;
endmodule

>>> sv/software_timer_table.sv
// software timer table top level: slot storage, sequencer and result register
// set and cancel: one key scan of the slots, then the result; start and end-ignored answer without a scan
// advance and end day: a full scan of the slots before each result
// throughput: one transaction at a time, next accepted after the last result is taken
// the slot compare unit walks one slot a cycle and sets the rate
// reset: synchronous active low, clears slot valid bits, time and date
module software_timer_table #(
    parameter int TIMER_SLOTS = stt_pkg::TIMER_SLOTS_DEF,
    parameter int CONSUMER_COUNT = stt_pkg::CONSUMER_COUNT_DEF,
    parameter int MAX_FIRES_PER_STEP = stt_pkg::MAX_FIRES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_kind,
    input  logic [3:0]  i_consumer_id,
    input  logic [31:0] i_event_id,
    input  logic [31:0] i_delay_ms,
    input  logic        i_repeat_flag,
    input  logic [31:0] i_target_ms,
    input  logic [31:0] i_day_date,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [3:0]  o_status,
    output logic [3:0]  o_fired_consumer,
    output logic [31:0] o_fired_event,
    output logic [31:0] o_time_now,
    output logic [31:0] o_date_now,
    output logic        o_last
);
    localparam int IW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;

    logic [TIMER_SLOTS-1:0] r_sv;
    logic [3:0]  r_cons [TIMER_SLOTS];
    logic [31:0] r_ev [TIMER_SLOTS];
    logic [31:0] r_due [TIMER_SLOTS];
    logic [31:0] r_int [TIMER_SLOTS];
    logic        r_rep [TIMER_SLOTS];

    stt_pkg::t_state r_state, n_state;
    logic [31:0] r_now, r_today;
    logic [2:0]  r_kind;
    logic [3:0]  r_kcons;
    logic [31:0] r_kev, r_delay, r_target;
    logic        r_krep;
    logic [5:0]  r_fires;
    logic        r_more_final;

    logic        r_ov;
    logic [3:0]  r_ost, r_ofc;
    logic [31:0] r_ofe;
    logic        r_olast;

    stt_pkg::t_scan_ctl sc;
    logic [IW-1:0] rd_idx, best, fidx;
    logic done, found, ffound;
    logic [31:0] best_due;
    logic out_free;
    logic [31:0] tgt;

    stt_scan #(.TIMER_SLOTS(TIMER_SLOTS)) u_scan (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(sc),
        .i_key_cons(r_kcons), .i_key_ev(r_kev),
        .o_rd_idx(rd_idx), .i_rd_valid(r_sv[rd_idx]), .i_rd_cons(r_cons[rd_idx]),
        .i_rd_ev(r_ev[rd_idx]), .i_rd_due(r_due[rd_idx]),
        .o_done(done), .o_found(found), .o_best(best), .o_best_due(best_due),
        .o_free_found(ffound), .o_free_idx(fidx)
    );

    assign out_free = !r_ov || !i_stall;
    assign o_stall = r_state != stt_pkg::S_IDLE || r_ov;
    assign tgt = (r_kind == stt_pkg::KIND_END) ? stt_pkg::END_OF_DAY_MS : r_target;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= stt_pkg::S_IDLE;
        else r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        sc.start = 1'b0;
        sc.key_mode = 1'b0;
        case (r_state)
            stt_pkg::S_IDLE: begin
                if (i_valid && !o_stall) begin
                    if (i_kind == stt_pkg::KIND_SET || i_kind == stt_pkg::KIND_CANCEL) begin
                        sc.start = 1'b1;
                        sc.key_mode = 1'b1;
                        n_state = stt_pkg::S_SCAN;
                    end else if (i_kind == stt_pkg::KIND_ADVANCE ||
                                 (i_kind == stt_pkg::KIND_END && i_day_date == r_today &&
                                  i_day_date != 32'd0)) begin
                        sc.start = 1'b1;
                        n_state = stt_pkg::S_SCAN;
                    end
                end
            end
            stt_pkg::S_SCAN: if (done) n_state = stt_pkg::S_DECIDE;
            stt_pkg::S_DECIDE: begin
                if (out_free) n_state = stt_pkg::S_UPDATE;
            end
            stt_pkg::S_UPDATE: begin
                if (r_kind == stt_pkg::KIND_SET || r_kind == stt_pkg::KIND_CANCEL ||
                    r_more_final) n_state = stt_pkg::S_IDLE;
                else begin
                    sc.start = 1'b1;
                    n_state = stt_pkg::S_SCAN;
                end
            end
            default: n_state = stt_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv <= '0;
            r_now <= '0;
            r_today <= '0;
            r_ov <= 1'b0;
            r_fires <= '0;
            r_more_final <= 1'b0;
        end else begin
            if (r_ov && !i_stall) r_ov <= 1'b0;
            case (r_state)
                stt_pkg::S_IDLE: begin
                    if (i_valid && !o_stall) begin
                        r_kind <= i_kind;
                        r_kcons <= i_consumer_id;
                        r_kev <= i_event_id;
                        r_delay <= i_delay_ms;
                        r_krep <= i_repeat_flag;
                        r_target <= i_target_ms;
                        r_fires <= '0;
                        r_more_final <= 1'b0;
                        r_ofc <= '0;
                        r_ofe <= '0;
                        r_olast <= 1'b1;
                        if (i_kind == stt_pkg::KIND_START) begin
                            r_today <= i_day_date;
                            r_now <= '0;
                            r_ov <= 1'b1;
                            r_ost <= stt_pkg::ST_DAY_START;
                        end else if (i_kind == stt_pkg::KIND_END &&
                                     (i_day_date != r_today || i_day_date == 32'd0)) begin
                            r_ov <= 1'b1;
                            r_ost <= stt_pkg::ST_END_IGN;
                        end
                    end
                end
                stt_pkg::S_DECIDE: begin
                    if (out_free) begin
                        r_ov <= 1'b1;
                        r_ofc <= '0;
                        r_ofe <= '0;
                        r_olast <= 1'b1;
                        if (r_kind == stt_pkg::KIND_SET) begin
                            if (found) r_ost <= stt_pkg::ST_DUP;
                            else if (!ffound || 32'(r_kcons) >= 32'(CONSUMER_COUNT))
                                r_ost <= stt_pkg::ST_FULL;
                            else if (r_krep && r_delay == 32'd0) r_ost <= stt_pkg::ST_ZERO;
                            else begin
                                r_ost <= stt_pkg::ST_SET_OK;
                                r_sv[fidx] <= 1'b1;
                                r_cons[fidx] <= r_kcons;
                                r_ev[fidx] <= r_kev;
                                r_due[fidx] <= r_now + r_delay;
                                r_int[fidx] <= r_delay;
                                r_rep[fidx] <= r_krep;
                            end
                        end else if (r_kind == stt_pkg::KIND_CANCEL) begin
                            if (found) begin
                                r_ost <= stt_pkg::ST_CANCEL_OK;
                                r_sv[best] <= 1'b0;
                            end else r_ost <= stt_pkg::ST_NOT_FOUND;
                        end else begin
                            if (found && best_due <= tgt &&
                                32'(r_fires) < 32'(MAX_FIRES_PER_STEP)) begin
                                r_ost <= stt_pkg::ST_FIRED;
                                r_ofc <= r_cons[best];
                                r_ofe <= r_ev[best];
                                r_olast <= 1'b0;
                                r_now <= best_due;
                                r_fires <= r_fires + 6'd1;
                                if (r_rep[best]) r_due[best] <= best_due + r_int[best];
                                else r_sv[best] <= 1'b0;
                            end else begin
                                r_more_final <= 1'b1;
                                r_now <= tgt;
                                if (r_kind == stt_pkg::KIND_END) begin
                                    r_ost <= stt_pkg::ST_DAY_END;
                                    r_sv <= '0;
                                end else if (found && best_due <= tgt)
                                    r_ost <= stt_pkg::ST_INCOMPLETE;
                                else r_ost <= stt_pkg::ST_ADV_DONE;
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_valid = r_ov;
    assign o_status = r_ost;
    assign o_fired_consumer = r_ofc;
    assign o_fired_event = r_ofe;
    assign o_time_now = r_now;
    assign o_date_now = r_today;
    assign o_last = r_olast;
endmodule
